/* sv/d96r_pkg.sv */
// Shared types and constants for the decimal96 round-to-integer unit.
// No dependencies; used by d96r_div10 and decimal96_round_to_integer_unit.
`default_nettype none

package d96r_pkg;

  // Field widths
  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned NLIMB     = 3;
  localparam int unsigned MANT_W    = LIMB_W * NLIMB;
  localparam int unsigned SCALE_W   = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned LIMB_IX_W = 2;
  localparam int unsigned IN_W      = 104;  // 2+64+32+5+1, whole bytes
  localparam int unsigned OUT_W     = 104;  // 64+32+5+1 = 102, padded

  // Default for the largest decimal scale
  localparam int unsigned MAX_SCALE_DEF = 28;

  // Divide-by-ten constants for one 32-bit limb with a carried-in remainder:
  //   (rem*2^32 + limb)/10 = rem*floor(2^32/10) + (rem*6 + limb)/10
  localparam int unsigned   DIV_T_W    = LIMB_W + 1;        // rem*6 + limb
  localparam int unsigned   DIV_SHIFT  = 35;
  localparam logic [31:0]   DIV_RECIP  = 32'hCCCC_CCCD;     // ceil(2^35/10)
  localparam logic [31:0]   LIMB_QUOT  = 32'd429496729;     // floor(2^32/10)
  localparam logic [3:0]    LIMB_REM   = 4'd6;              // 2^32 mod 10
  localparam logic [3:0]    HALF_DIGIT = 4'd5;

  // Action codes
  typedef enum logic [1:0] {
    ACT_NEGATE   = 2'd0,
    ACT_TRUNCATE = 2'd1,
    ACT_FLOOR    = 2'd2,
    ACT_ROUND    = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Result of one limb step of the shared divider
  typedef struct packed {
    logic [LIMB_W-1:0]  quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

/* sv/d96r_div10.sv */
// Shared divide-by-ten unit: one 32-bit limb plus carried remainder per cycle.
// Depends on d96r_pkg for widths and reciprocal constants.
`default_nettype none

module d96r_div10 (
  input  wire logic [d96r_pkg::DIGIT_W-1:0] rem_in,
  input  wire logic [d96r_pkg::LIMB_W-1:0]  limb_in,
  output d96r_pkg::div_res_t                res
);

  localparam int unsigned PROD_W = d96r_pkg::DIV_T_W + d96r_pkg::LIMB_W;

  logic [d96r_pkg::DIV_T_W-1:0]                   t;
  logic [d96r_pkg::DIV_T_W+d96r_pkg::LIMB_W-1:0]  prod;
  logic [d96r_pkg::LIMB_W-1:0]                    q_part;
  logic [d96r_pkg::LIMB_W-1:0]                    q_hi;
  logic [d96r_pkg::DIGIT_W-1:0]                   q10_lo;

  // Fold the carried remainder into the limb, then divide by reciprocal
  always_comb begin
    t = {1'b0, limb_in}
        + d96r_pkg::DIV_T_W'(rem_in) * d96r_pkg::DIV_T_W'(d96r_pkg::LIMB_REM);
    prod = PROD_W'(t) * PROD_W'(d96r_pkg::DIV_RECIP);
    q_part = d96r_pkg::LIMB_W'(prod >> d96r_pkg::DIV_SHIFT);
    // Contribution of the carried remainder to the limb quotient
    q_hi = d96r_pkg::LIMB_W'(rem_in) * d96r_pkg::LIMB_QUOT;
    res.quot = q_hi + q_part;
    // Remainder is below ten, so four low bits of t - 10*q suffice
    q10_lo = {q_part[0], 3'b000} + {q_part[2:0], 1'b0};
    res.rem = t[d96r_pkg::DIGIT_W-1:0] - q10_lo;
  end

endmodule

`default_nettype wire

/* sv/decimal96_round_to_integer_unit.sv */
// Negate or scale zero skips the divide loop; otherwise the word is divided by
// ten scale times (scale saturated to MAX_SCALE), each divide-by-ten step taking
// one 32-bit limb at a time through the single shared d96r_div10 unit.
// Throughput: one word at a time; in_tready is high only while idle.
// Reset: rst_n synchronous, active low; clears the sequencer and out_tvalid.
// Depends on d96r_pkg and d96r_div10.
`default_nettype none

module decimal96_round_to_integer_unit #(
  parameter int unsigned MAX_SCALE = d96r_pkg::MAX_SCALE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // in_tdata: action[1:0], mant_low[65:2], mant_high[97:66],
  //           scale[102:98], negative[103]
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [d96r_pkg::IN_W-1:0]    in_tdata,
  // out_tdata: res_low[63:0], res_high[95:64], res_scale[100:96],
  //            res_negative[101], zero pad [103:102]
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [d96r_pkg::OUT_W-1:0]        out_tdata
);

  localparam int unsigned LW = d96r_pkg::LIMB_W;
  localparam logic [d96r_pkg::SCALE_W-1:0] MAX_SC = d96r_pkg::SCALE_W'(MAX_SCALE);
  localparam logic [d96r_pkg::LIMB_IX_W-1:0] TOP_LIMB =
    d96r_pkg::LIMB_IX_W'(d96r_pkg::NLIMB - 1);

  // Unpacked input fields
  d96r_pkg::action_t              in_action;
  logic [d96r_pkg::MANT_W-1:0]    in_mant;
  logic [d96r_pkg::SCALE_W-1:0]   in_scale;
  logic                           in_neg;
  logic [d96r_pkg::SCALE_W-1:0]   scale_sat;

  // Working registers
  d96r_pkg::state_t                state_r, state_nxt;
  d96r_pkg::action_t               act_r, act_nxt;
  logic [LW-1:0]                   limb_r [d96r_pkg::NLIMB];
  logic [LW-1:0]                   limb_nxt [d96r_pkg::NLIMB];
  logic [d96r_pkg::SCALE_W-1:0]    scale_r, scale_nxt;
  logic [d96r_pkg::SCALE_W-1:0]    cnt_r, cnt_nxt;
  logic [d96r_pkg::LIMB_IX_W-1:0]  idx_r, idx_nxt;
  logic [d96r_pkg::DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [d96r_pkg::DIGIT_W-1:0]    last_r, last_nxt;
  logic                            nz_r, nz_nxt;
  logic                            neg_r, neg_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [d96r_pkg::OUT_W-1:0]      out_data_r, out_data_nxt;

  // Shared divider port
  logic [LW-1:0]                   div_limb;
  d96r_pkg::div_res_t              div_res;

  logic                            inc;
  logic [d96r_pkg::MANT_W-1:0]     mant_cur;
  logic [d96r_pkg::MANT_W-1:0]     mant_res;
  logic [d96r_pkg::SCALE_W-1:0]    res_scale;
  logic                            res_neg;
  logic                            out_free;

  assign in_action = d96r_pkg::action_t'(in_tdata[1:0]);
  assign in_mant   = in_tdata[97:2];
  assign in_scale  = in_tdata[102:98];
  assign in_neg    = in_tdata[103];
  assign scale_sat = (in_scale > MAX_SC) ? MAX_SC : in_scale;

  assign in_tready  = (state_r == d96r_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Select the limb under division
  always_comb begin
    unique case (idx_r)
      2'd0:    div_limb = limb_r[0];
      2'd1:    div_limb = limb_r[1];
      2'd2:    div_limb = limb_r[2];
      default: div_limb = limb_r[0];
    endcase
  end

  d96r_div10 u_div10 (
    .rem_in  (rem_r),
    .limb_in (div_limb),
    .res     (div_res)
  );

  // Rounding increment and final result assembly
  always_comb begin
    mant_cur = {limb_r[2], limb_r[1], limb_r[0]};
    unique case (act_r)
      d96r_pkg::ACT_FLOOR: inc = neg_r && nz_r;
      d96r_pkg::ACT_ROUND: inc = (last_r >= d96r_pkg::HALF_DIGIT);
      default:             inc = 1'b0;
    endcase
    mant_res = mant_cur + d96r_pkg::MANT_W'(inc);
    if (act_r == d96r_pkg::ACT_NEGATE) begin
      res_scale = scale_r;
      res_neg   = !neg_r;
    end else begin
      res_scale = '0;
      res_neg   = neg_r;
    end
  end

  // Sequencer: load, divide limb by limb unless negating or scale is zero, then hand off to the output register
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    limb_nxt      = limb_r;
    scale_nxt     = scale_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;
    nz_nxt        = nz_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      d96r_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt     = in_action;
          limb_nxt[0] = in_mant[LW-1:0];
          limb_nxt[1] = in_mant[2*LW-1:LW];
          limb_nxt[2] = in_mant[3*LW-1:2*LW];
          scale_nxt   = scale_sat;
          cnt_nxt     = scale_sat;
          idx_nxt     = TOP_LIMB;
          rem_nxt     = '0;
          last_nxt    = '0;
          nz_nxt      = 1'b0;
          neg_nxt     = in_neg;
          if (in_action == d96r_pkg::ACT_NEGATE || scale_sat == '0) begin
            state_nxt = d96r_pkg::ST_DONE;
          end else begin
            state_nxt = d96r_pkg::ST_DIV;
          end
        end
      end
      d96r_pkg::ST_DIV: begin
        limb_nxt[idx_r] = div_res.quot;
        rem_nxt         = div_res.rem;
        if (idx_r == '0) begin
          // Whole number divided: keep the dropped digit, start next pass or finish
          last_nxt = div_res.rem;
          nz_nxt   = nz_r || (div_res.rem != '0);
          rem_nxt  = '0;
          idx_nxt  = TOP_LIMB;
          cnt_nxt  = cnt_r - d96r_pkg::SCALE_W'(1);
          if (cnt_r == 5'd1) begin
            state_nxt = d96r_pkg::ST_DONE;
          end
        end else begin
          idx_nxt = idx_r - d96r_pkg::LIMB_IX_W'(1);
        end
      end
      d96r_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, res_neg, res_scale, mant_res};
          state_nxt     = d96r_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = d96r_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= d96r_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    limb_r     <= limb_nxt;
    scale_r    <= scale_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    last_r     <= last_nxt;
    nz_r       <= nz_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result word appears only when the sequencer finishes an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == d96r_pkg::ST_DONE))
    else $error("result word raised outside the finish state");

  // The divide loop never runs with an exhausted digit count
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == d96r_pkg::ST_DIV) |-> (cnt_r != '0 && cnt_r <= MAX_SC))
    else $error("divide loop with bad digit count");

  // The limb pointer stays within the mantissa
  a_div_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == d96r_pkg::ST_DIV) |-> (idx_r <= TOP_LIMB))
    else $error("limb pointer out of range");

  // A finished item is never dropped while the output word is stalled
  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == d96r_pkg::ST_DONE && out_tvalid && !out_tready)
      |=> (state_r == d96r_pkg::ST_DONE))
    else $error("finished item left while output stalled");

endmodule

`default_nettype wire
